[rtl/gvn_pkg.sv]
// gvn_pkg: shared constants and types for the grid vertex normal unit.
// No dependencies; imported by the engine and the top level.
package gvn_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_COORD_BITS = 16;

  localparam int GW_W = 9;
  localparam int GH_W = 13;
  localparam int COL_W = 8;
  localparam int ROW_W = 12;
  localparam int ROW_LIMIT = 4096;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [GW_W-1:0] GRID_WIDTH_RST  = 9'd256;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 13'd4096;

  // serial arithmetic widths
  localparam int MUL_W  = 31;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;
  localparam int Q_W    = 15;
  localparam int UNIT_SHIFT = 14;
  localparam int NUM_W  = MUL_W + UNIT_SHIFT + 1;
  localparam int CNT_W  = 5;
  localparam int SQRT_STEPS = 32;
  localparam int NORM_W = 16;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic [Q_W-1:0]           normal_z;
    logic                     degenerate;
  } gvn_norm_t;

endpackage

[rtl/gvn_ram.sv]
// gvn_ram: generic single-port RAM, registered read.
// No dependencies.
module gvn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/gvn_engine.sv]
// gvn_engine: cross product, scaling, square root and division for one normal,
// all bit-serial; products and squares share one shift-add multiplier. Depends on gvn_pkg.
module gvn_engine import gvn_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [3*COORD_BITS-1:0] vtx_v,
  input  logic [3*COORD_BITS-1:0] vtx_n1,
  input  logic [3*COORD_BITS-1:0] vtx_n2,
  output logic                    done,
  output gvn_norm_t               result
);

  localparam int PRE = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int FW  = COORD_BITS + 1;
  localparam int DW  = COORD_BITS + 1 - PRE;

  typedef enum logic [3:0] {
    E_IDLE, E_LOAD, E_MUL, E_ACC, E_SCALE, E_SQRT, E_DLOAD, E_DIV, E_DSTORE, E_FIN
  } estate_t;

  function automatic logic [DW-1:0] diff(input logic [COORD_BITS-1:0] n,
                                         input logic [COORD_BITS-1:0] v);
    logic [FW-1:0] d;
    logic [FW-1:0] mg;
    logic [FW-1:0] sh;
    logic [DW-1:0] t;
    d  = {n[COORD_BITS-1], n} - {v[COORD_BITS-1], v};
    mg = d[FW-1] ? (~d + 1'b1) : d;
    sh = mg >> PRE;
    t  = sh[DW-1:0];
    return d[FW-1] ? (~t + 1'b1) : t;
  endfunction

  function automatic logic [MUL_W-1:0] mag_d(input logic [DW-1:0] x);
    logic [DW-1:0] t;
    t = x[DW-1] ? (~x + 1'b1) : x;
    return MUL_W'(t);
  endfunction

  estate_t           state;
  logic [DW-1:0]     da [3];
  logic [DW-1:0]     db [3];
  logic [1:0]        k;
  logic              half;
  logic              sq;
  logic [PROD_W-1:0] mcand;
  logic [MUL_W-1:0]  mplier;
  logic [PROD_W-1:0] prod;
  logic              psign;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W:0]   acc;
  logic [PROD_W-1:0] cmag [3];
  logic [2:0]        csign;
  logic [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] rem_d;
  logic [Q_W-1:0]    nlo;
  logic [Q_W-1:0]    q;
  logic [Q_W-1:0]    qv [3];
  logic              degen;

  logic [1:0]        ia;
  logic [1:0]        ib;
  logic [PROD_W:0]   pval;
  logic [PROD_W:0]   nacc;
  logic [REM_W-1:0]  rem_n;
  logic [REM_W-1:0]  trial;
  logic [NUM_W-1:0]  num;
  logic [ROOT_W:0]   dt;
  logic [ROOT_W:0]   dsub;
  logic              dge;
  logic              too_big;
  logic              all_zero;
  logic              neg;
  logic [2:0]        osign;

  always_comb begin
    case (k)
      2'd0: begin
        ia = half ? 2'd2 : 2'd1;
        ib = half ? 2'd1 : 2'd2;
      end
      2'd1: begin
        ia = half ? 2'd0 : 2'd2;
        ib = half ? 2'd2 : 2'd0;
      end
      2'd2: begin
        ia = half ? 2'd1 : 2'd0;
        ib = half ? 2'd0 : 2'd1;
      end
      default: begin
        ia = 2'd0;
        ib = 2'd0;
      end
    endcase
  end

  always_comb begin
    pval  = psign ? (~{1'b0, prod} + 1'b1) : {1'b0, prod};
    nacc  = acc - pval;
    rem_n = {rem[REM_W-3:0], sum[SUM_W-1:SUM_W-2]};
    trial = REM_W'({root, 2'b01});
    num   = NUM_W'({cmag[k][MUL_W-1:0], UNIT_SHIFT'(0)}) + NUM_W'(root >> 1);
    dt    = {rem_d, nlo[Q_W-1]};
    dsub  = dt - {1'b0, root};
    dge   = dt >= {1'b0, root};
    too_big  = (|cmag[0][PROD_W-1:MUL_W]) | (|cmag[1][PROD_W-1:MUL_W])
             | (|cmag[2][PROD_W-1:MUL_W]);
    all_zero = (cmag[0] == '0) && (cmag[1] == '0) && (cmag[2] == '0);
    neg   = csign[2] && (cmag[2] != '0);
    osign = csign ^ {3{neg}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == E_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              da[i] <= diff(vtx_n1[i*COORD_BITS +: COORD_BITS],
                            vtx_v[i*COORD_BITS +: COORD_BITS]);
              db[i] <= diff(vtx_n2[i*COORD_BITS +: COORD_BITS],
                            vtx_v[i*COORD_BITS +: COORD_BITS]);
            end
            k     <= 2'd0;
            half  <= 1'b0;
            sq    <= 1'b0;
            degen <= 1'b0;
            state <= E_LOAD;
          end
        end
        E_LOAD: begin
          if (sq) begin
            mcand  <= PROD_W'(cmag[k][MUL_W-1:0]);
            mplier <= cmag[k][MUL_W-1:0];
            psign  <= 1'b0;
          end else begin
            mcand  <= PROD_W'(mag_d(da[ia]));
            mplier <= mag_d(db[ib]);
            psign  <= da[ia][DW-1] ^ db[ib][DW-1];
          end
          prod  <= '0;
          cnt   <= '0;
          state <= E_MUL;
        end
        E_MUL: begin
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_W - 1)) begin
            state <= E_ACC;
          end
        end
        E_ACC: begin
          if (sq) begin
            sum <= sum + SUM_W'(prod);
            if (k == 2'd2) begin
              root  <= '0;
              rem   <= '0;
              cnt   <= '0;
              state <= E_SQRT;
            end else begin
              k     <= k + 1'b1;
              state <= E_LOAD;
            end
          end else if (!half) begin
            acc   <= pval;
            half  <= 1'b1;
            state <= E_LOAD;
          end else begin
            cmag[k]  <= nacc[PROD_W] ? PROD_W'(~nacc + 1'b1) : nacc[PROD_W-1:0];
            csign[k] <= nacc[PROD_W];
            half     <= 1'b0;
            if (k == 2'd2) begin
              k     <= 2'd0;
              state <= E_SCALE;
            end else begin
              k     <= k + 1'b1;
              state <= E_LOAD;
            end
          end
        end
        E_SCALE: begin
          if (all_zero) begin
            degen <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              qv[i] <= '0;
            end
            state <= E_FIN;
          end else if (too_big) begin
            for (int i = 0; i < 3; i++) begin
              cmag[i] <= cmag[i] >> 1;
            end
          end else begin
            sq    <= 1'b1;
            sum   <= '0;
            state <= E_LOAD;
          end
        end
        E_SQRT: begin
          if (rem_n >= trial) begin
            rem  <= rem_n - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_n;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          sum <= sum << 2;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            k     <= 2'd0;
            state <= E_DLOAD;
          end
        end
        E_DLOAD: begin
          rem_d <= ROOT_W'(num[NUM_W-1:Q_W]);
          nlo   <= num[Q_W-1:0];
          q     <= '0;
          cnt   <= '0;
          state <= E_DIV;
        end
        E_DIV: begin
          rem_d <= dge ? dsub[ROOT_W-1:0] : dt[ROOT_W-1:0];
          q     <= {q[Q_W-2:0], dge};
          nlo   <= nlo << 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(Q_W - 1)) begin
            state <= E_DSTORE;
          end
        end
        E_DSTORE: begin
          qv[k] <= q;
          if (k == 2'd2) begin
            state <= E_FIN;
          end else begin
            k     <= k + 1'b1;
            state <= E_DLOAD;
          end
        end
        E_FIN: begin
          result.normal_x   <= osign[0] ? -$signed({1'b0, qv[0]}) : $signed({1'b0, qv[0]});
          result.normal_y   <= osign[1] ? -$signed({1'b0, qv[1]}) : $signed({1'b0, qv[1]});
          result.normal_z   <= qv[2];
          result.degenerate <= degen;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

[rtl/grid_vertex_normal_unit.sv]
// grid_vertex_normal_unit: per-vertex unit normals for a raster-order height grid.
// Depends on gvn_pkg, gvn_ram (one row of vertices) and gvn_engine.
//
//  channel | handshake          | word
//  cfg     | cfg_write          | cfg_index, cfg_data
//  in      | in_valid/in_stall  | vertex_x, vertex_y, vertex_z
//  out     | out_valid/out_stall| grid_col, grid_row, normal_x/y/z, degenerate, last
//
// One input word at a time: row-store access and bookkeeping, then per normal the serial
// engine work (six 31-step products, three squares, 32-step root, three 15-step divides).
// Reset is synchronous; grid size returns to 256 x 4096 and the counters to zero.
// A stalled output word holds; the next input is taken while it waits.
module grid_vertex_normal_unit import gvn_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic signed [COORD_BITS-1:0] vertex_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COL_W-1:0]             grid_col,
  output logic [ROW_W-1:0]             grid_row,
  output logic signed [NORM_W-1:0]     normal_x,
  output logic signed [NORM_W-1:0]     normal_y,
  output logic [Q_W-1:0]               normal_z,
  output logic                         degenerate,
  output logic                         last
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > GW_W) ? $clog2(MAX_WIDTH + 1) : GW_W;
  localparam int VW = 3 * COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_ABOVE, S_RD_SIDE, S_NEXT, S_RUN, S_EMIT, S_WRITE
  } state_t;

  typedef enum logic [1:0] {JOB_BELOW, JOB_LEFT, JOB_CORNER} job_t;

  state_t          state;
  logic [GW_W-1:0] grid_width;
  logic [GH_W-1:0] grid_height;
  logic [AW-1:0]   column_count;
  logic [ROW_W-1:0] row_count;
  logic [VW-1:0]   cur;
  logic [VW-1:0]   above;
  logic [VW-1:0]   side;
  logic [VW-1:0]   saved_above_left;
  logic [VW-1:0]   previous_vertex;
  logic [AW-1:0]   cur_c;
  logic [ROW_W-1:0] cur_r;
  logic [2:0]      jobs;
  job_t            job_sel;
  logic [COL_W-1:0] job_col;
  logic [ROW_W-1:0] job_row;
  logic            job_last;
  logic            eng_start;

  logic [WW-1:0]   w_cl;
  logic [GH_W-1:0] h_cl;
  logic [AW-1:0]   c_cl;
  logic [ROW_W-1:0] r_cl;
  logic            c_last;
  logic            r_last;
  logic [2:0]      pick;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [VW-1:0]   ram_rdata;
  logic [VW-1:0]   eng_v;
  logic [VW-1:0]   eng_n1;
  logic [VW-1:0]   eng_n2;
  logic            eng_done;
  gvn_norm_t       eng_res;

  always_comb begin
    if (WW'(grid_width) < WW'(2)) begin
      w_cl = WW'(2);
    end else if (WW'(grid_width) > WW'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(grid_width);
    end
    if (grid_height < GH_W'(2)) begin
      h_cl = GH_W'(2);
    end else if (grid_height > GH_W'(ROW_LIMIT)) begin
      h_cl = GH_W'(ROW_LIMIT);
    end else begin
      h_cl = grid_height;
    end
    c_cl   = (WW'(column_count) >= w_cl) ? AW'(w_cl - 1'b1) : column_count;
    r_cl   = (GH_W'(row_count) >= h_cl) ? ROW_W'(h_cl - 1'b1) : row_count;
    c_last = WW'(cur_c) == (w_cl - 1'b1);
    r_last = GH_W'(cur_r) == (h_cl - 1'b1);
    pick   = jobs[0] ? 3'b001 : (jobs[1] ? 3'b010 : 3'b100);
  end

  assign in_stall = (state != S_IDLE);
  assign ram_we   = (state == S_WRITE);

  always_comb begin
    unique case (state)
      S_IDLE:     ram_addr = c_cl;
      S_RD_ABOVE: ram_addr = cur_c + 1'b1;
      default:    ram_addr = cur_c;
    endcase
  end

  always_comb begin
    unique case (job_sel)
      JOB_LEFT: begin
        eng_v  = previous_vertex;
        eng_n1 = saved_above_left;
        eng_n2 = cur;
      end
      JOB_CORNER: begin
        eng_v  = cur;
        eng_n1 = above;
        eng_n2 = previous_vertex;
      end
      default: begin
        eng_v  = above;
        eng_n1 = cur;
        eng_n2 = side;
      end
    endcase
  end

  gvn_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cur),
    .rdata (ram_rdata)
  );

  gvn_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (eng_start),
    .vtx_v  (eng_v),
    .vtx_n1 (eng_n1),
    .vtx_n2 (eng_n2),
    .done   (eng_done),
    .result (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      eng_start <= 1'b0;
    end else begin
      eng_start <= (state == S_NEXT) && (jobs != 3'b000);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      grid_width       <= GRID_WIDTH_RST;
      grid_height      <= GRID_HEIGHT_RST;
      column_count     <= '0;
      row_count        <= '0;
      saved_above_left <= '0;
      previous_vertex  <= '0;
      job_sel          <= JOB_BELOW;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur   <= {vertex_z, vertex_y, vertex_x};
            cur_c <= c_cl;
            cur_r <= r_cl;
            state <= S_RD_ABOVE;
          end
        end
        S_RD_ABOVE: begin
          above <= ram_rdata;
          state <= S_RD_SIDE;
        end
        S_RD_SIDE: begin
          side  <= c_last ? saved_above_left : ram_rdata;
          jobs  <= {r_last && c_last, r_last && (cur_c != '0), cur_r != '0};
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (jobs == 3'b000) begin
            state <= S_WRITE;
          end else begin
            if (pick[0]) begin
              job_sel <= JOB_BELOW;
              job_col <= COL_W'(cur_c);
              job_row <= cur_r - 1'b1;
            end else if (pick[1]) begin
              job_sel <= JOB_LEFT;
              job_col <= COL_W'(cur_c - 1'b1);
              job_row <= cur_r;
            end else begin
              job_sel <= JOB_CORNER;
              job_col <= COL_W'(cur_c);
              job_row <= cur_r;
            end
            jobs      <= jobs & ~pick;
            job_last  <= (jobs & ~pick) == 3'b000;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          if (eng_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            grid_col   <= job_col;
            grid_row   <= job_row;
            normal_x   <= eng_res.normal_x;
            normal_y   <= eng_res.normal_y;
            normal_z   <= eng_res.normal_z;
            degenerate <= eng_res.degenerate;
            last       <= job_last;
            state      <= S_NEXT;
          end
        end
        S_WRITE: begin
          saved_above_left <= above;
          previous_vertex  <= cur;
          if (c_last) begin
            column_count <= '0;
            row_count    <= r_last ? '0 : cur_r + 1'b1;
          end else begin
            column_count <= cur_c + 1'b1;
            row_count    <= cur_r;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH: begin
            grid_width   <= cfg_data[GW_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          CFG_GRID_HEIGHT: begin
            grid_height  <= cfg_data[GH_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
